// ----- hdl/length_prefix_frame_buffer_assert.svh -----
// Assertion macros shared by the frame buffer RTL
`ifndef LENGTH_PREFIX_FRAME_BUFFER_ASSERT_SVH
`define LENGTH_PREFIX_FRAME_BUFFER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LPFB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lpfb assertion failed");
// next-cycle implication
`define LPFB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lpfb assertion failed");
`else
`define LPFB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LPFB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/lpfb_pkg.sv -----
// Shared types, codes and constants of the length-prefixed frame buffer
`timescale 1ns / 1ps
package lpfb_pkg;

	localparam int DEF_BUF_BYTES    = 4096;
	localparam int DEF_RECORD_SLOTS = 64;

	localparam int OP_W     = 2;
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 13;
	localparam int READY_W  = 7;

	localparam int HDR_BYTES   = 4;
	localparam int MISSING_SAT = 8191;

	localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
	localparam logic [OP_W-1:0] OP_PULL  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [STATUS_W-1:0] RS_PUSH_OK   = 3'd0;
	localparam logic [STATUS_W-1:0] RS_NO_ROOM   = 3'd1;
	localparam logic [STATUS_W-1:0] RS_REJECTED  = 3'd2;
	localparam logic [STATUS_W-1:0] RS_DELIVERED = 3'd3;
	localparam logic [STATUS_W-1:0] RS_NOT_READY = 3'd4;
	localparam logic [STATUS_W-1:0] RS_EMPTY_REC = 3'd5;
	localparam logic [STATUS_W-1:0] RS_CLEARED   = 3'd6;
	localparam logic [STATUS_W-1:0] RS_SKIPPED   = 3'd7;

	typedef enum logic {
		CS_IDLE,
		CS_EXEC
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic exec;
	} ctl_cmd_t;

endpackage

// ----- hdl/lpfb_chan_if.sv -----
// Valid/ready channel interfaces for item and result beats
`timescale 1ns / 1ps
interface lpfb_in_if;
	import lpfb_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [BYTE_W-1:0] in_byte;
	modport source (output valid, op, in_byte, input ready);
	modport sink (input valid, op, in_byte, output ready);
endinterface

interface lpfb_out_if;
	import lpfb_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [BYTE_W-1:0]   out_byte;
	logic                last;
	logic [COUNT_W-1:0]  used_bytes;
	logic [COUNT_W-1:0]  missing_bytes;
	logic [READY_W-1:0]  records_ready;
	modport source (output valid, status, out_byte, last, used_bytes, missing_bytes,
		records_ready, input ready);
	modport sink (input valid, status, out_byte, last, used_bytes, missing_bytes,
		records_ready, output ready);
endinterface

// ----- hdl/lpfb_ctrl.sv -----
// Controller: beat handshake sequencing and result register valid
`timescale 1ns / 1ps
`include "length_prefix_frame_buffer_assert.svh"
module lpfb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output lpfb_pkg::ctl_cmd_t cmd
);
	import lpfb_pkg::*;

	ctl_state_t state_q, state_nxt;
	logic       out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			CS_IDLE: begin
				if (cmd.accept) begin
					state_nxt = CS_EXEC;
				end
			end
			CS_EXEC: begin
				state_nxt = CS_IDLE;
			end
			default: begin
				state_nxt = CS_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.exec   = 1'b0;
		case (state_q)
			CS_IDLE: begin
				in_ready = !out_valid_q || out_ready;
			end
			CS_EXEC: begin
				cmd.exec = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		cmd.accept = in_ready && in_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`LPFB_ASSERT_NXT(a_accept_exec, clk, arst_n, cmd.accept, state_q == CS_EXEC)
	`LPFB_ASSERT_NXT(a_exec_presents, clk, arst_n, state_q == CS_EXEC, out_valid_q && state_q == CS_IDLE)
	`LPFB_ASSERT_IMP(a_exec_slot_free, clk, arst_n, state_q == CS_EXEC, !out_valid_q)

endmodule

// ----- hdl/lpfb_datapath.sv -----
// Datapath: byte store, length queue, record tracking and result register
`timescale 1ns / 1ps
`include "length_prefix_frame_buffer_assert.svh"
module lpfb_datapath #(
	parameter int BUF_BYTES    = lpfb_pkg::DEF_BUF_BYTES,
	parameter int RECORD_SLOTS = lpfb_pkg::DEF_RECORD_SLOTS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lpfb_pkg::ctl_cmd_t              cmd,
	input  logic                            cfg_we,
	input  logic                            cfg_wdata,
	input  logic [lpfb_pkg::OP_W-1:0]       op,
	input  logic [lpfb_pkg::BYTE_W-1:0]     in_byte,
	output logic [lpfb_pkg::STATUS_W-1:0]   res_status,
	output logic [lpfb_pkg::BYTE_W-1:0]     res_byte,
	output logic                            res_last,
	output logic [lpfb_pkg::COUNT_W-1:0]    res_used,
	output logic [lpfb_pkg::COUNT_W-1:0]    res_missing,
	output logic [lpfb_pkg::READY_W-1:0]    res_ready
);
	import lpfb_pkg::*;

	localparam int PTR_W = $clog2(BUF_BYTES);
	localparam int CNT_W = $clog2(BUF_BYTES + 1);
	localparam int QP_W  = $clog2(RECORD_SLOTS);
	localparam int QC_W  = $clog2(RECORD_SLOTS + 1);

	// memories
	logic [BYTE_W-1:0] store_mem [BUF_BYTES];
	logic [CNT_W-1:0]  len_mem [RECORD_SLOTS];
	logic [BYTE_W-1:0] store_rd_q;
	logic [CNT_W-1:0]  len_rd_q;

	// state
	logic              mode_q;
	logic [OP_W-1:0]   op_q;
	logic [BYTE_W-1:0] byte_q;
	logic [PTR_W-1:0]  rd_ptr_q, wr_ptr_q;
	logic [CNT_W-1:0]  used_q, tail_q, head_off_q;
	logic [23:0]       hdr_shift_q;
	logic [1:0]        hdr_cnt_q;
	logic [31:0]       skip_q;
	logic [QP_W-1:0]   q_head_q, q_tail_q;
	logic [QC_W-1:0]   q_count_q, complete_q;

	// next state
	logic [PTR_W-1:0]  n_rd_ptr, n_wr_ptr;
	logic [CNT_W-1:0]  n_used, n_tail, n_head_off;
	logic [23:0]       n_hdr_shift;
	logic [1:0]        n_hdr_cnt;
	logic [31:0]       n_skip;
	logic [QP_W-1:0]   n_q_head, n_q_tail;
	logic [QC_W-1:0]   n_q_count, n_complete;

	logic [STATUS_W-1:0] st;
	logic [BYTE_W-1:0]   ob;
	logic                lst;
	logic [COUNT_W-1:0]  miss;
	logic                store_we, len_we;
	logic                room;
	logic [31:0]         hdr_full, free_bytes, used_w, ready_w;
	logic [CNT_W-1:0]    off_inc;
	logic [PTR_W-1:0]    wr_ptr_inc, rd_ptr_inc;
	logic [QP_W-1:0]     q_head_inc, q_tail_inc;
	logic [31:0]         tail_w;

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[wr_ptr_q] <= byte_q;
		end
		store_rd_q <= store_mem[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem[q_tail_q] <= CNT_W'(hdr_full);
		end
		len_rd_q <= len_mem[q_head_q];
	end

	always_comb begin
		wr_ptr_inc = (wr_ptr_q == PTR_W'(BUF_BYTES - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
		rd_ptr_inc = (rd_ptr_q == PTR_W'(BUF_BYTES - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
		q_head_inc = (q_head_q == QP_W'(RECORD_SLOTS - 1)) ? '0 : q_head_q + QP_W'(1);
		q_tail_inc = (q_tail_q == QP_W'(RECORD_SLOTS - 1)) ? '0 : q_tail_q + QP_W'(1);
		room       = used_q < CNT_W'(BUF_BYTES);
		hdr_full   = {hdr_shift_q, byte_q};
		free_bytes = 32'(BUF_BYTES) - 32'(used_q);
		off_inc    = head_off_q + CNT_W'(1);
	end

	always_comb begin
		n_rd_ptr    = rd_ptr_q;
		n_wr_ptr    = wr_ptr_q;
		n_used      = used_q;
		n_tail      = tail_q;
		n_head_off  = head_off_q;
		n_hdr_shift = hdr_shift_q;
		n_hdr_cnt   = hdr_cnt_q;
		n_skip      = skip_q;
		n_q_head    = q_head_q;
		n_q_tail    = q_tail_q;
		n_q_count   = q_count_q;
		n_complete  = complete_q;
		st          = RS_NOT_READY;
		ob          = '0;
		lst         = 1'b0;
		store_we    = 1'b0;
		len_we      = 1'b0;
		case (op_q)
			OP_PUSH: begin
				if (!mode_q) begin
					if (room) begin
						store_we = 1'b1;
						n_wr_ptr = wr_ptr_inc;
						n_used   = used_q + CNT_W'(1);
						st       = RS_PUSH_OK;
					end else begin
						st = RS_NO_ROOM;
					end
				end else if (skip_q != 32'd0) begin
					n_skip = skip_q - 32'd1;
					st     = RS_SKIPPED;
				end else if (tail_q != '0) begin
					if (room) begin
						store_we = 1'b1;
						n_wr_ptr = wr_ptr_inc;
						n_used   = used_q + CNT_W'(1);
						n_tail   = tail_q - CNT_W'(1);
						if (tail_q == CNT_W'(1)) begin
							n_complete = complete_q + QC_W'(1);
						end
						st = RS_PUSH_OK;
					end else begin
						st = RS_NO_ROOM;
					end
				end else if (hdr_cnt_q != 2'd3) begin
					n_hdr_shift = {hdr_shift_q[15:0], byte_q};
					n_hdr_cnt   = hdr_cnt_q + 2'd1;
					st          = RS_PUSH_OK;
				end else begin
					n_hdr_shift = '0;
					n_hdr_cnt   = '0;
					if (hdr_full > free_bytes || q_count_q == QC_W'(RECORD_SLOTS)) begin
						n_skip = hdr_full;
						st     = RS_REJECTED;
					end else begin
						len_we    = 1'b1;
						n_q_tail  = q_tail_inc;
						n_q_count = q_count_q + QC_W'(1);
						if (hdr_full == 32'd0) begin
							n_complete = complete_q + QC_W'(1);
						end else begin
							n_tail = CNT_W'(hdr_full);
						end
						st = RS_PUSH_OK;
					end
				end
			end
			OP_PULL: begin
				if (!mode_q) begin
					if (used_q != '0) begin
						ob       = store_rd_q;
						n_rd_ptr = rd_ptr_inc;
						n_used   = used_q - CNT_W'(1);
						st       = RS_DELIVERED;
						lst      = (used_q == CNT_W'(1));
					end
				end else if (complete_q != '0) begin
					if (len_rd_q == '0) begin
						n_q_head   = q_head_inc;
						n_q_count  = q_count_q - QC_W'(1);
						n_complete = complete_q - QC_W'(1);
						n_head_off = '0;
						st         = RS_EMPTY_REC;
					end else if (used_q != '0) begin
						ob         = store_rd_q;
						n_rd_ptr   = rd_ptr_inc;
						n_used     = used_q - CNT_W'(1);
						n_head_off = off_inc;
						st         = RS_DELIVERED;
						if (off_inc >= len_rd_q) begin
							lst        = 1'b1;
							n_q_head   = q_head_inc;
							n_q_count  = q_count_q - QC_W'(1);
							n_complete = complete_q - QC_W'(1);
							n_head_off = '0;
						end
					end
				end
			end
			OP_CLEAR: begin
				n_rd_ptr    = '0;
				n_wr_ptr    = '0;
				n_used      = '0;
				n_tail      = '0;
				n_head_off  = '0;
				n_hdr_shift = '0;
				n_hdr_cnt   = '0;
				n_skip      = '0;
				n_q_head    = '0;
				n_q_tail    = '0;
				n_q_count   = '0;
				n_complete  = '0;
				st          = RS_CLEARED;
			end
			default: begin
				st = RS_NOT_READY;
			end
		endcase
	end

	// bytes still owed to the newest record, seen after this beat, and the used and ready counts
	always_comb begin
		tail_w = 32'(n_tail);
		miss   = '0;
		if (mode_q) begin
			if (n_skip != 32'd0) begin
				miss = (n_skip > 32'(MISSING_SAT)) ? COUNT_W'(MISSING_SAT) : n_skip[COUNT_W-1:0];
			end else if (n_tail != '0) begin
				miss = tail_w[COUNT_W-1:0];
			end else if (n_hdr_cnt != '0) begin
				miss = COUNT_W'(HDR_BYTES) - COUNT_W'(n_hdr_cnt);
			end
		end
		used_w  = 32'(n_used);
		ready_w = 32'(n_complete);
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= op;
			byte_q <= in_byte;
		end
		if (cmd.exec) begin
			res_status  <= st;
			res_byte    <= ob;
			res_last    <= lst;
			res_used    <= used_w[COUNT_W-1:0];
			res_missing <= miss;
			res_ready   <= ready_w[READY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b1;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			used_q      <= '0;
			tail_q      <= '0;
			head_off_q  <= '0;
			hdr_shift_q <= '0;
			hdr_cnt_q   <= '0;
			skip_q      <= '0;
			q_head_q    <= '0;
			q_tail_q    <= '0;
			q_count_q   <= '0;
			complete_q  <= '0;
		end else if (cfg_we) begin
			mode_q      <= cfg_wdata;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			used_q      <= '0;
			tail_q      <= '0;
			head_off_q  <= '0;
			hdr_shift_q <= '0;
			hdr_cnt_q   <= '0;
			skip_q      <= '0;
			q_head_q    <= '0;
			q_tail_q    <= '0;
			q_count_q   <= '0;
			complete_q  <= '0;
		end else if (cmd.exec) begin
			rd_ptr_q    <= n_rd_ptr;
			wr_ptr_q    <= n_wr_ptr;
			used_q      <= n_used;
			tail_q      <= n_tail;
			head_off_q  <= n_head_off;
			hdr_shift_q <= n_hdr_shift;
			hdr_cnt_q   <= n_hdr_cnt;
			skip_q      <= n_skip;
			q_head_q    <= n_q_head;
			q_tail_q    <= n_q_tail;
			q_count_q   <= n_q_count;
			complete_q  <= n_complete;
		end
	end

	`LPFB_ASSERT_IMP(a_used_bound, clk, arst_n, 1'b1, used_q <= CNT_W'(BUF_BYTES))
	`LPFB_ASSERT_IMP(a_complete_le_queued, clk, arst_n, 1'b1, complete_q <= q_count_q)
	`LPFB_ASSERT_IMP(a_skip_exclusive, clk, arst_n, skip_q != 32'd0, tail_q == '0 && hdr_cnt_q == '0)

endmodule

// ----- hdl/length_prefix_frame_buffer.sv -----
// Top level of the length-prefixed frame buffer.
// Channel req carries one item per beat: op (push, pull, clear) and in_byte.
// Channel rsp returns exactly one result beat per item: status, out_byte,
// last, used_bytes, missing_bytes and records_ready.
// cfg_we/cfg_wdata write framed_mode; a write also empties the buffer.
// An accepted item is registered, then executed in the EXEC state, which
// registers its result. No new item is taken while one executes; each item
// reads the byte store and the length queue at its accept edge and updates
// them as EXEC ends. While a result is held, a new item is taken only at the
// edge where it leaves; while the receiver stalls, req.ready stays low.
// Reset: pointers and counters clear, framed mode is set, store contents are
// left as they are (never read before written); no clearing pass is needed.
`timescale 1ns / 1ps
module length_prefix_frame_buffer #(
	parameter int BUF_BYTES    = lpfb_pkg::DEF_BUF_BYTES,
	parameter int RECORD_SLOTS = lpfb_pkg::DEF_RECORD_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	lpfb_in_if.sink     req,
	lpfb_out_if.source  rsp
);
	import lpfb_pkg::*;

	ctl_cmd_t cmd;

	lpfb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	lpfb_datapath #(
		.BUF_BYTES    (BUF_BYTES),
		.RECORD_SLOTS (RECORD_SLOTS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.op          (req.op),
		.in_byte     (req.in_byte),
		.res_status  (rsp.status),
		.res_byte    (rsp.out_byte),
		.res_last    (rsp.last),
		.res_used    (rsp.used_bytes),
		.res_missing (rsp.missing_bytes),
		.res_ready   (rsp.records_ready)
	);

endmodule

// ----- bench/length_prefix_frame_buffer_tb.sv -----
// Self-checking testbench for the length-prefixed frame buffer
`timescale 1ns / 1ps
module length_prefix_frame_buffer_tb;
	import lpfb_pkg::*;

	localparam int unsigned BUF_BYTES    = DEF_BUF_BYTES;
	localparam int unsigned RECORD_SLOTS = DEF_RECORD_SLOTS;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int LONG_HOLD   = 400;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BYTE_W-1:0]   out_byte;
		logic                last;
		logic [COUNT_W-1:0]  used_bytes;
		logic [COUNT_W-1:0]  missing_bytes;
		logic [READY_W-1:0]  records_ready;
	} beat_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	lpfb_in_if  req_ch ();
	lpfb_out_if rsp_ch ();

	length_prefix_frame_buffer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// buffer state mirror
	logic [7:0]         fb_mem [BUF_BYTES];
	logic [COUNT_W-1:0] fb_len_q [RECORD_SLOTS];
	logic [11:0]        fb_rd, fb_wr;
	logic [COUNT_W-1:0] fb_used, fb_tail, fb_head_off;
	logic [31:0]        fb_hdr, fb_skip;
	logic [2:0]         fb_hdr_cnt;
	logic [5:0]         fb_q_head, fb_q_tail;
	logic [6:0]         fb_q_cnt, fb_done;
	logic               fb_framed;

	beat_result_t pending_results [$];
	int           beats_sent;
	int           fail_count = 0;
	bit           steady;
	int           hold_requests = 0;
	int           holds_served = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void empty_buffer();
		fb_rd = '0;
		fb_wr = '0;
		fb_used = '0;
		fb_hdr = '0;
		fb_hdr_cnt = '0;
		fb_tail = '0;
		fb_skip = '0;
		fb_q_head = '0;
		fb_q_tail = '0;
		fb_q_cnt = '0;
		fb_done = '0;
		fb_head_off = '0;
	endfunction

	function automatic bit append_byte(logic [7:0] b);
		if (fb_used >= BUF_BYTES)
			return 1'b0;
		fb_mem[fb_wr] = b;
		fb_wr++;
		fb_used++;
		return 1'b1;
	endfunction

	function automatic logic [7:0] take_byte();
		logic [7:0] b;
		b = fb_mem[fb_rd];
		fb_rd++;
		fb_used--;
		return b;
	endfunction

	function automatic void retire_record();
		fb_q_head++;
		fb_q_cnt--;
		fb_done--;
		fb_head_off = '0;
	endfunction

	function automatic beat_result_t buffer_step(logic [OP_W-1:0] op, logic [7:0] b);
		beat_result_t r;
		logic [31:0]  len;
		r = '0;
		r.status = RS_NOT_READY;
		case (op)
			OP_PUSH: begin
				if (!fb_framed) begin
					r.status = append_byte(b) ? RS_PUSH_OK : RS_NO_ROOM;
				end else if (fb_skip != 0) begin
					fb_skip--;
					r.status = RS_SKIPPED;
				end else if (fb_tail != 0) begin
					if (append_byte(b)) begin
						fb_tail--;
						if (fb_tail == 0)
							fb_done++;
						r.status = RS_PUSH_OK;
					end else begin
						r.status = RS_NO_ROOM;
					end
				end else begin
					fb_hdr = {fb_hdr[23:0], b};
					fb_hdr_cnt++;
					r.status = RS_PUSH_OK;
					if (fb_hdr_cnt == HDR_BYTES) begin
						len = fb_hdr;
						fb_hdr = '0;
						fb_hdr_cnt = '0;
						if (len > BUF_BYTES - fb_used || fb_q_cnt >= RECORD_SLOTS) begin
							fb_skip = len;
							r.status = RS_REJECTED;
						end else begin
							fb_len_q[fb_q_tail] = len[COUNT_W-1:0];
							fb_q_tail++;
							fb_q_cnt++;
							if (len == 0)
								fb_done++;
							else
								fb_tail = len[COUNT_W-1:0];
						end
					end
				end
			end
			OP_PULL: begin
				if (fb_framed) begin
					if (fb_done != 0) begin
						len = 32'(fb_len_q[fb_q_head]);
						if (len == 0) begin
							retire_record();
							r.status = RS_EMPTY_REC;
						end else if (fb_used != 0) begin
							r.out_byte = take_byte();
							fb_head_off++;
							r.status = RS_DELIVERED;
							if (fb_head_off >= len) begin
								r.last = 1'b1;
								retire_record();
							end
						end
					end
				end else if (fb_used != 0) begin
					r.out_byte = take_byte();
					r.status = RS_DELIVERED;
					r.last = (fb_used == 0);
				end
			end
			OP_CLEAR: begin
				empty_buffer();
				r.status = RS_CLEARED;
			end
			default: ;
		endcase
		if (fb_framed) begin
			if (fb_skip != 0)
				r.missing_bytes = (fb_skip > MISSING_SAT) ? COUNT_W'(MISSING_SAT)
					: fb_skip[COUNT_W-1:0];
			else if (fb_tail != 0)
				r.missing_bytes = fb_tail;
			else if (fb_hdr_cnt != 0)
				r.missing_bytes = COUNT_W'(HDR_BYTES - fb_hdr_cnt);
		end
		r.used_bytes = fb_used;
		r.records_ready = fb_done;
		return r;
	endfunction

	function automatic void check_field(string what, logic [31:0] want_v, logic [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
			fail_count++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		beat_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected beat, expected none, actual status %0d",
					$time, rsp_ch.status);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(want.status), 32'(rsp_ch.status));
				check_field("out_byte", 32'(want.out_byte), 32'(rsp_ch.out_byte));
				check_field("last", 32'(want.last), 32'(rsp_ch.last));
				check_field("used_bytes", 32'(want.used_bytes), 32'(rsp_ch.used_bytes));
				check_field("missing_bytes", 32'(want.missing_bytes),
					32'(rsp_ch.missing_bytes));
				check_field("records_ready", 32'(want.records_ready),
					32'(rsp_ch.records_ready));
			end
		end
	end

	// receiver back-pressure
	initial begin : result_sink
		rsp_ch.ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_requests != holds_served) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				holds_served++;
			end else if (!steady && $urandom_range(0, 2) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				repeat (steady ? 1 : $urandom_range(1, 18)) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	task automatic send_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b);
		if (!steady && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.in_byte <= b;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		pending_results.push_back(buffer_step(op, b));
		beats_sent++;
	endtask

	task automatic push_header(logic [31:0] len);
		send_item(OP_PUSH, len[31:24]);
		send_item(OP_PUSH, len[23:16]);
		send_item(OP_PUSH, len[15:8]);
		send_item(OP_PUSH, len[7:0]);
	endtask

	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_mode(logic framed);
		wait_for_results();
		repeat (4) @(posedge clk);
		cfg_wdata <= framed;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		fb_framed = framed;
		empty_buffer();
	endtask

	task automatic test_framed_basics();
		send_item(OP_PULL, 8'hff);
		send_item(OP_UNUSED, 8'h00);
		send_item(OP_PUSH, 8'h00);
		send_item(OP_PUSH, 8'h00);
		send_item(OP_PUSH, 8'h00);
		send_item(OP_PUSH, 8'h02);
		send_item(OP_PUSH, 8'h00);
		send_item(OP_PUSH, 8'hff);
		send_item(OP_PULL, 8'h00);
		send_item(OP_PULL, 8'h00);
		push_header(32'd0);
		send_item(OP_PULL, 8'h5a);
		// oversized length, skip count saturates
		push_header(32'h00ff_ffff);
		send_item(OP_PUSH, 8'haa);
		send_item(OP_PUSH, 8'h55);
		send_item(OP_CLEAR, 8'h00);
		send_item(OP_PULL, 8'h00);
	endtask

	task automatic test_record_slots();
		repeat (RECORD_SLOTS) push_header(32'd0);
		push_header(32'd0);
		push_header(32'd3);
		repeat (3) send_item(OP_PUSH, 8'($urandom));
		repeat (RECORD_SLOTS + 1) send_item(OP_PULL, 8'($urandom));
	endtask

	task automatic test_receiver_stall();
		wait_for_results();
		hold_requests++;
		push_header(32'd40);
		repeat (40) send_item(OP_PUSH, 8'($urandom));
		push_header(32'd0);
		repeat (42) send_item(OP_PULL, 8'($urandom));
		// longer than the free space
		push_header(32'd5000);
		repeat (3) send_item(OP_PUSH, 8'($urandom));
		send_item(OP_CLEAR, 8'($urandom));
		send_item(OP_PULL, 8'($urandom));
	endtask

	task automatic test_unframed();
		int p;
		write_mode(1'b0);
		send_item(OP_PULL, 8'h00);
		repeat (64) send_item(OP_PUSH, 8'($urandom));
		repeat (65) send_item(OP_PULL, 8'($urandom));
		repeat (150) begin
			p = $urandom_range(0, 99);
			if (p < 55)
				send_item(OP_PUSH, 8'($urandom));
			else if (p < 90)
				send_item(OP_PULL, 8'($urandom));
			else if (p < 95)
				send_item(OP_UNUSED, 8'($urandom));
			else
				send_item(OP_CLEAR, 8'($urandom));
		end
	endtask

	task automatic test_framed_random(int n);
		int stop_at;
		int p;
		int len;
		stop_at = beats_sent + n;
		while (beats_sent < stop_at) begin
			p = $urandom_range(0, 99);
			if (p < 50) begin
				p = $urandom_range(0, 99);
				len = (p < 85) ? $urandom_range(0, 16)
					: (p < 98) ? $urandom_range(17, 120) : $urandom_range(121, 600);
				push_header(32'(len));
				repeat (len) begin
					if ($urandom_range(0, 5) == 0)
						send_item(OP_PULL, 8'($urandom));
					send_item(OP_PUSH, 8'($urandom));
				end
			end else if (p < 80) begin
				repeat ($urandom_range(1, 24)) send_item(OP_PULL, 8'($urandom));
			end else if (p < 88) begin
				send_item(OP_UNUSED, 8'($urandom));
			end else if (p < 93) begin
				// broken header
				repeat ($urandom_range(1, 3)) send_item(OP_PUSH, 8'($urandom));
				send_item(OP_CLEAR, 8'($urandom));
			end else if (p < 96) begin
				if ($urandom_range(0, 1))
					push_header(32'($urandom_range(BUF_BYTES + 1, MISSING_SAT)));
				else
					push_header($urandom | 32'h0100_0000);
				repeat ($urandom_range(1, 5)) send_item(OP_PUSH, 8'($urandom));
				send_item(OP_CLEAR, 8'($urandom));
			end else begin
				send_item(OP_CLEAR, 8'($urandom));
			end
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b1;
		req_ch.valid = 1'b0;
		req_ch.op = OP_PUSH;
		req_ch.in_byte = '0;
		beats_sent = 0;
		steady = 1'b0;
		fb_framed = 1'b1;
		empty_buffer();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_framed_basics();
		test_record_slots();
		test_receiver_stall();
		test_unframed();
		write_mode(1'b1);
		write_mode(1'b1);
		test_framed_random(420);
		wait_for_results();
		steady = 1'b1;
		test_framed_random(120);
		wait_for_results();
		repeat (8) @(posedge clk);

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
